// ----- rtl/iwm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// iwm_pkg
// Shared types and constants for the write-only I2C master.
// -----------------------------------------------------------------------------
package iwm_pkg;

	localparam int BUFFER_DEPTH = 8;
	localparam int BUF_AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
	localparam logic [2:0] BIT_MSB = 3'd7;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_BEGIN = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_code_t;

	typedef enum logic [1:0] {
		K_TICK,
		K_LOAD,
		K_BEGIN,
		K_ILLEGAL
	} kind_t;

	typedef enum logic [3:0] {
		PH_IDLE = 4'd0,
		PH_ST1  = 4'd1,
		PH_ST2  = 4'd2,
		PH_ST3  = 4'd3,
		PH_BSET = 4'd4,
		PH_BHI  = 4'd5,
		PH_BLO  = 4'd6,
		PH_AREL = 4'd7,
		PH_AHI  = 4'd8,
		PH_ASMP = 4'd9,
		PH_SP1  = 4'd10,
		PH_SP2  = 4'd11,
		PH_SP3  = 4'd12
	} phase_t;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] data_byte;
		logic [6:0] target_addr;
		logic       sda_in;
	} in_word_t;

	typedef struct packed {
		logic scl_low;
		logic sda_low;
		logic busy_res;
		logic done_res;
		logic addr_acked;
		logic rejected;
	} out_word_t;

	// Classified word as it travels through the queue.
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic [6:0] target_addr;
		logic       sda_in;
	} op_t;

	typedef struct packed {
		logic valid;
		logic full;
	} q_status_t;

endpackage

`default_nettype wire

// ----- rtl/iwm_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// iwm_front
// Accepts command words, classifies them and holds them for the queue.
// -----------------------------------------------------------------------------
module iwm_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_stall,
	input  wire iwm_pkg::in_word_t   cmd,
	input  wire iwm_pkg::q_status_t  q_status,
	output logic                     push,
	output iwm_pkg::op_t             push_op
);

	logic          valid_s1;
	iwm_pkg::op_t  op_s1;
	iwm_pkg::kind_t kind;
	logic          take;

	always_comb begin
		case (iwm_pkg::cmd_code_t'(cmd.command))
			iwm_pkg::CMD_TICK:  kind = iwm_pkg::K_TICK;
			iwm_pkg::CMD_LOAD:  kind = iwm_pkg::K_LOAD;
			iwm_pkg::CMD_BEGIN: kind = iwm_pkg::K_BEGIN;
			default:            kind = iwm_pkg::K_ILLEGAL;
		endcase
	end

	assign push      = valid_s1 && !q_status.full;
	assign cmd_stall = valid_s1 && q_status.full;
	assign take      = cmd_valid && !cmd_stall;
	assign push_op   = op_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1.kind        <= kind;
			op_s1.data_byte   <= cmd.data_byte;
			op_s1.target_addr <= cmd.target_addr;
			op_s1.sda_in      <= cmd.sda_in;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/iwm_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// iwm_queue
// Two-entry queue of classified words between the front and the back.
// -----------------------------------------------------------------------------
module iwm_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire iwm_pkg::op_t       push_op,
	input  wire logic               pop,
	output iwm_pkg::q_status_t      q_status,
	output iwm_pkg::op_t            head
);

	iwm_pkg::op_t entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;

	assign q_status.valid = (count_q != 2'd0);
	assign q_status.full  = (count_q == 2'd2);
	assign head           = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/iwm_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// iwm_back
// Bus sequencer: byte buffer, phase machine and the result register.
// -----------------------------------------------------------------------------
module iwm_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire iwm_pkg::q_status_t q_status,
	input  wire iwm_pkg::op_t       head,
	output logic                    pop,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output iwm_pkg::out_word_t      res
);

	iwm_pkg::phase_t              phase_q, phase_d;
	logic [2:0]                   bit_q, bit_d;
	logic [iwm_pkg::CNT_W-1:0]    byte_q, byte_d;
	logic [iwm_pkg::CNT_W-1:0]    count_q, count_d;
	logic [6:0]                   addr_q, addr_d;
	logic                         ack_q, ack_d;
	logic                         scl_q, scl_d;
	logic                         sda_q, sda_d;
	logic                         done_d;
	logic                         rej_d;
	logic                         wr_en;
	logic [7:0]                   buf_q [iwm_pkg::BUFFER_DEPTH];
	logic [iwm_pkg::CNT_W-1:0]    rd_off;
	logic [7:0]                   cur_byte;
	logic                         busy;
	logic                         tick;
	logic                         res_valid_q;
	iwm_pkg::out_word_t           res_q;

	assign busy = (phase_q != iwm_pkg::PH_IDLE);
	assign tick = (head.kind == iwm_pkg::K_TICK) && busy;
	assign pop  = q_status.valid && (!res_valid_q || !res_stall);

	assign rd_off = byte_q - iwm_pkg::CNT_W'(1);

	always_comb begin
		if (byte_q == '0) begin
			cur_byte = {addr_q, 1'b0};
		end else if (rd_off < iwm_pkg::CNT_W'(iwm_pkg::BUFFER_DEPTH)) begin
			cur_byte = buf_q[rd_off[iwm_pkg::BUF_AW-1:0]];
		end else begin
			cur_byte = 8'd0;
		end
	end

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (head.kind == iwm_pkg::K_BEGIN && !busy) begin
			phase_d = iwm_pkg::PH_ST1;
		end else if (tick) begin
			case (phase_q)
				iwm_pkg::PH_ST1:  phase_d = iwm_pkg::PH_ST2;
				iwm_pkg::PH_ST2:  phase_d = iwm_pkg::PH_ST3;
				iwm_pkg::PH_ST3:  phase_d = iwm_pkg::PH_BSET;
				iwm_pkg::PH_BSET: phase_d = iwm_pkg::PH_BHI;
				iwm_pkg::PH_BHI:  phase_d = iwm_pkg::PH_BLO;
				iwm_pkg::PH_BLO:
					phase_d = (bit_q == 3'd0) ? iwm_pkg::PH_AREL : iwm_pkg::PH_BSET;
				iwm_pkg::PH_AREL: phase_d = iwm_pkg::PH_AHI;
				iwm_pkg::PH_AHI:  phase_d = iwm_pkg::PH_ASMP;
				iwm_pkg::PH_ASMP: begin
					// A missing address acknowledge goes straight to stop.
					if (byte_q == '0 && head.sda_in) begin
						phase_d = iwm_pkg::PH_SP1;
					end else if (byte_q < count_q) begin
						phase_d = iwm_pkg::PH_BSET;
					end else begin
						phase_d = iwm_pkg::PH_SP1;
					end
				end
				iwm_pkg::PH_SP1:  phase_d = iwm_pkg::PH_SP2;
				iwm_pkg::PH_SP2:  phase_d = iwm_pkg::PH_SP3;
				default:          phase_d = iwm_pkg::PH_IDLE;
			endcase
		end
	end

	// Pins, counters, buffer write and flags.
	always_comb begin
		bit_d   = bit_q;
		byte_d  = byte_q;
		count_d = count_q;
		addr_d  = addr_q;
		ack_d   = ack_q;
		scl_d   = scl_q;
		sda_d   = sda_q;
		done_d  = 1'b0;
		rej_d   = 1'b0;
		wr_en   = 1'b0;
		case (head.kind)
			iwm_pkg::K_TICK: begin
				if (busy) begin
					case (phase_q)
						iwm_pkg::PH_ST1: begin
							scl_d = 1'b0;
							sda_d = 1'b0;
						end
						iwm_pkg::PH_ST2: begin
							scl_d = 1'b0;
							sda_d = 1'b1;
						end
						iwm_pkg::PH_ST3: begin
							scl_d  = 1'b1;
							sda_d  = 1'b1;
							byte_d = '0;
							bit_d  = iwm_pkg::BIT_MSB;
						end
						iwm_pkg::PH_BSET: begin
							scl_d = 1'b1;
							sda_d = !cur_byte[bit_q];
						end
						iwm_pkg::PH_BHI: begin
							scl_d = 1'b0;
						end
						iwm_pkg::PH_BLO: begin
							scl_d = 1'b1;
							if (bit_q != 3'd0) begin
								bit_d = bit_q - 3'd1;
							end
						end
						iwm_pkg::PH_AREL: begin
							scl_d = 1'b1;
							sda_d = 1'b0;
						end
						iwm_pkg::PH_AHI: begin
							scl_d = 1'b0;
							sda_d = 1'b0;
						end
						iwm_pkg::PH_ASMP: begin
							scl_d = 1'b1;
							sda_d = 1'b0;
							if (byte_q == '0) begin
								ack_d = !head.sda_in;
							end
							if (!(byte_q == '0 && head.sda_in) && byte_q < count_q) begin
								byte_d = byte_q + iwm_pkg::CNT_W'(1);
								bit_d  = iwm_pkg::BIT_MSB;
							end
						end
						iwm_pkg::PH_SP1: begin
							scl_d = 1'b1;
							sda_d = 1'b1;
						end
						iwm_pkg::PH_SP2: begin
							scl_d = 1'b0;
							sda_d = 1'b1;
						end
						iwm_pkg::PH_SP3: begin
							scl_d   = 1'b0;
							sda_d   = 1'b0;
							done_d  = 1'b1;
							count_d = '0;
							byte_d  = '0;
							bit_d   = iwm_pkg::BIT_MSB;
						end
						default: begin
						end
					endcase
				end
			end
			iwm_pkg::K_LOAD: begin
				if (busy || count_q >= iwm_pkg::CNT_W'(iwm_pkg::BUFFER_DEPTH)) begin
					rej_d = 1'b1;
				end else begin
					wr_en   = 1'b1;
					count_d = count_q + iwm_pkg::CNT_W'(1);
				end
			end
			iwm_pkg::K_BEGIN: begin
				if (busy) begin
					rej_d = 1'b1;
				end else begin
					addr_d = head.target_addr;
					ack_d  = 1'b0;
					byte_d = '0;
					bit_d  = iwm_pkg::BIT_MSB;
				end
			end
			default: begin
				rej_d = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= iwm_pkg::PH_IDLE;
			bit_q       <= iwm_pkg::BIT_MSB;
			byte_q      <= '0;
			count_q     <= '0;
			addr_q      <= 7'd0;
			ack_q       <= 1'b0;
			scl_q       <= 1'b0;
			sda_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_d;
				bit_q   <= bit_d;
				byte_q  <= byte_d;
				count_q <= count_d;
				addr_q  <= addr_d;
				ack_q   <= ack_d;
				scl_q   <= scl_d;
				sda_q   <= sda_d;
			end
			if (pop) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && wr_en) begin
			buf_q[count_q[iwm_pkg::BUF_AW-1:0]] <= head.data_byte;
		end
		if (pop) begin
			res_q.scl_low    <= scl_d;
			res_q.sda_low    <= sda_d;
			res_q.busy_res   <= (phase_d != iwm_pkg::PH_IDLE);
			res_q.done_res   <= done_d;
			res_q.addr_acked <= ack_d;
			res_q.rejected   <= rej_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

// ----- rtl/i2c_write_master.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Path: a command word passes through the front register, a queue entry and the
// result register before its result word is on the outputs.
// Throughput: one word per cycle while res_stall and cmd_stall stay low; every
// command, tick or not, is taken by the phase machine in the back end.
// Reset: arst_n clears the phase machine, counters, pin drive, flags and the
// queue at once; the byte buffer holds no defined value until loaded.
// -----------------------------------------------------------------------------
// i2c_write_master
// Tick-driven write-only I2C master with open-drain pin drive.
// -----------------------------------------------------------------------------
module i2c_write_master (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_stall,
	input  wire iwm_pkg::in_word_t  cmd,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output iwm_pkg::out_word_t      res
);

	iwm_pkg::q_status_t q_status;
	iwm_pkg::op_t       push_op;
	iwm_pkg::op_t       head;
	logic               push;
	logic               pop;

	iwm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.q_status  (q_status),
		.push      (push),
		.push_op   (push_op)
	);

	iwm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_op  (push_op),
		.pop      (pop),
		.q_status (q_status),
		.head     (head)
	);

	iwm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.head      (head),
		.pop       (pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

`default_nettype wire
